// ----- rtl/core/sept_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_pkg
// Shared codes and types for the sorted endpoint table.
// ----------------------------------------------------------------------------
package sept_pkg;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_MOVE   = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // sweep direction of the moving endpoint
  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef struct packed {
    logic dir;
    logic mover_is_min;
  } order_ctl_t;

endpackage

// ----- rtl/core/sept_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sept_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sept_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_order
// Shared compare unit: decides whether the moving endpoint swaps with its
// neighbor. Min endpoints sort before max endpoints at equal values.
// ----------------------------------------------------------------------------
module sept_order
  import sept_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  order_ctl_t                    ctl,
  input  logic signed [VALUE_BITS-1:0] mover_value,
  input  logic signed [VALUE_BITS-1:0] nb_value,
  input  logic                          nb_is_min,
  output logic                          swap
);

  logic nb_gt;
  logic nb_lt;
  logic nb_eq;

  assign nb_gt = nb_value > mover_value;
  assign nb_lt = nb_value < mover_value;
  assign nb_eq = nb_value == mover_value;

  always_comb begin
    if (ctl.dir == DIR_LEFT) begin
      swap = nb_gt || (nb_eq && ctl.mover_is_min && !nb_is_min);
    end else begin
      swap = nb_lt || (nb_eq && !ctl.mover_is_min && nb_is_min);
    end
  end

endmodule

// ----- rtl/core/sorted_endpoint_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_endpoint_table_core
// One axis of a sweep-and-prune broad phase: endpoint table kept sorted by
// incremental insertion with adjacent swaps.
// ----------------------------------------------------------------------------
// Usage:
//   Drive action, object_key, min_value and max_value and raise start; the
//   item is taken at a clock edge with start high and busy low. Insert
//   appends a new object (key = current object count), move rewrites both
//   bounds of an existing object. Each endpoint walks to its place one
//   adjacent swap per cycle through the shared compare unit, reading one
//   neighbor a cycle from the endpoint memory.
//   A full table or an unknown key answers in the cycle after acceptance;
//   busy stays low for such a refused item. For an accepted insert or move
//   busy stays high for the whole item; one item is worked at a time.
//   The result shows on result_key, min_position, max_position and status
//   for one cycle with done high; the receiver cannot stall it.
//   Reset clears the object count and the sequencer; the endpoint and index
//   memories are not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module sorted_endpoint_table_core
  import sept_pkg::*;
#(
  parameter int MAX_OBJECTS = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [7:0]  object_key,
  input  logic signed [31:0] min_value,
  input  logic signed [31:0] max_value,
  output logic        done,
  output logic [7:0]  result_key,
  output logic [8:0]  min_position,
  output logic [8:0]  max_position,
  output logic [1:0]  status
);

  localparam int SLOTS  = 2 * MAX_OBJECTS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int KEY_W  = $clog2(MAX_OBJECTS);
  localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int NW     = SLOT_W + 2;
  localparam int EW     = VALUE_BITS + 1 + KEY_W;
  localparam int KW     = CNT_W + 8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MINRD = 4'd1;
  localparam logic [3:0] ST_LREQ  = 4'd2;
  localparam logic [3:0] ST_LCMP  = 4'd3;
  localparam logic [3:0] ST_RREQ  = 4'd4;
  localparam logic [3:0] ST_RCMP  = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;
  localparam logic [3:0] ST_MAXRD = 4'd7;
  localparam logic [3:0] ST_RESRD = 4'd8;

  // sequencer state
  logic [3:0]                   state, state_next;
  logic [CNT_W-1:0]             count, count_next;
  logic [KEY_W-1:0]             key, key_next;
  logic signed [VALUE_BITS-1:0] hi, hi_next;
  logic signed [VALUE_BITS-1:0] mv_value, mv_value_next;
  logic                         mv_is_min, mv_is_min_next;
  logic [SLOT_W-1:0]            pos, pos_next;
  logic [SLOT_W-1:0]            max_pos, max_pos_next;

  // result registers
  logic       done_next;
  logic [7:0] result_key_next;
  logic [8:0] min_position_next;
  logic [8:0] max_position_next;
  logic [1:0] status_next;

  // memory ports
  logic              ept_we;
  logic [SLOT_W-1:0] ept_waddr, ept_raddr;
  logic [EW-1:0]     ept_wdata, ept_rdata;
  logic              min_we, max_we;
  logic [KEY_W-1:0]  min_waddr, max_waddr, min_raddr, max_raddr;
  logic [SLOT_W-1:0] min_wdata, max_wdata, min_rdata, max_rdata;

  // neighbor fields
  logic signed [VALUE_BITS-1:0] nb_value;
  logic                         nb_is_min;
  logic [KEY_W-1:0]             nb_owner;
  order_ctl_t                   ctl;
  logic                         swap;

  // input decode
  logic signed [63:0]           lo_ext, hi_ext;
  logic signed [VALUE_BITS-1:0] lo_in, hi_in;
  logic [KEY_W+7:0]             key_wide;
  logic [KEY_W-1:0]             key_in;
  logic [NW-1:0]                n_slots;
  logic [SLOT_W-1:0]            base_slot;
  logic [KEY_W+8:0]             rkey_wide;
  logic [SLOT_W+8:0]            minp_wide, maxp_wide;

  assign lo_ext   = {{32{min_value[31]}}, min_value};
  assign hi_ext   = {{32{max_value[31]}}, max_value};
  assign lo_in    = lo_ext[VALUE_BITS-1:0];
  assign hi_in    = hi_ext[VALUE_BITS-1:0];
  assign key_wide = (KEY_W + 8)'(object_key);
  assign key_in   = key_wide[KEY_W-1:0];
  assign n_slots  = NW'({count, 1'b0});
  assign base_slot = SLOT_W'({count, 1'b0});

  assign rkey_wide = (KEY_W + 9)'(key);
  assign minp_wide = (SLOT_W + 9)'(min_rdata);
  assign maxp_wide = (SLOT_W + 9)'(max_pos);

  assign nb_value  = ept_rdata[EW-1 -: VALUE_BITS];
  assign nb_is_min = ept_rdata[KEY_W];
  assign nb_owner  = ept_rdata[KEY_W-1:0];

  assign ctl.dir = (state == ST_LREQ || state == ST_LCMP) ? DIR_LEFT : DIR_RIGHT;
  assign ctl.mover_is_min = mv_is_min;

  assign busy = (state != ST_IDLE);

  sept_order #(
    .VALUE_BITS(VALUE_BITS)
  ) u_order (
    .ctl        (ctl),
    .mover_value(mv_value),
    .nb_value   (nb_value),
    .nb_is_min  (nb_is_min),
    .swap       (swap)
  );

  sept_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ept_ram (
    .clk  (clk),
    .we   (ept_we),
    .waddr(ept_waddr),
    .wdata(ept_wdata),
    .raddr(ept_raddr),
    .rdata(ept_rdata)
  );

  sept_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_OBJECTS)
  ) u_min_ram (
    .clk  (clk),
    .we   (min_we),
    .waddr(min_waddr),
    .wdata(min_wdata),
    .raddr(min_raddr),
    .rdata(min_rdata)
  );

  sept_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_OBJECTS)
  ) u_max_ram (
    .clk  (clk),
    .we   (max_we),
    .waddr(max_waddr),
    .wdata(max_wdata),
    .raddr(max_raddr),
    .rdata(max_rdata)
  );

  // read the next neighbor of the endpoint at its next position
  assign ept_raddr = (ctl.dir == DIR_LEFT) ? pos_next - 1'b1 : pos_next + 1'b1;

  always_comb begin
    state_next        = state;
    count_next        = count;
    key_next          = key;
    hi_next           = hi;
    mv_value_next     = mv_value;
    mv_is_min_next    = mv_is_min;
    pos_next          = pos;
    max_pos_next      = max_pos;
    done_next         = 1'b0;
    result_key_next   = result_key;
    min_position_next = min_position;
    max_position_next = max_position;
    status_next       = status;
    ept_we            = 1'b0;
    ept_waddr         = pos;
    ept_wdata         = ept_rdata;
    min_we            = 1'b0;
    max_we            = 1'b0;
    min_waddr         = nb_owner;
    max_waddr         = nb_owner;
    min_wdata         = pos;
    max_wdata         = pos;
    min_raddr         = key;
    max_raddr         = key;

    case (state)
      ST_IDLE: begin
        min_raddr = key_in;
        if (start) begin
          case (action)
            ACT_INSERT: begin
              if (count == CNT_W'(MAX_OBJECTS)) begin
                done_next         = 1'b1;
                result_key_next   = 8'd0;
                min_position_next = 9'd0;
                max_position_next = 9'd0;
                status_next       = STATUS_FULL;
              end else begin
                // place the max endpoint behind the new min endpoint
                key_next       = count[KEY_W-1:0];
                ept_we         = 1'b1;
                ept_waddr      = base_slot | SLOT_W'(1);
                ept_wdata      = {hi_in, 1'b0, count[KEY_W-1:0]};
                max_we         = 1'b1;
                max_waddr      = count[KEY_W-1:0];
                max_wdata      = base_slot | SLOT_W'(1);
                pos_next       = base_slot;
                mv_value_next  = lo_in;
                mv_is_min_next = 1'b1;
                hi_next        = hi_in;
                count_next     = count + 1'b1;
                state_next     = ST_LREQ;
              end
            end
            ACT_MOVE: begin
              if (KW'(object_key) >= KW'(count)) begin
                done_next         = 1'b1;
                result_key_next   = object_key;
                min_position_next = 9'd0;
                max_position_next = 9'd0;
                status_next       = STATUS_UNKNOWN;
              end else begin
                key_next       = key_in;
                mv_value_next  = lo_in;
                mv_is_min_next = 1'b1;
                hi_next        = hi_in;
                state_next     = ST_MINRD;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_MINRD: begin
        pos_next   = min_rdata;
        state_next = ST_LREQ;
      end

      ST_LREQ: begin
        state_next = (pos == '0) ? ST_RREQ : ST_LCMP;
      end

      ST_LCMP: begin
        if (swap) begin
          // drop the neighbor into the current slot, advance left
          ept_we    = 1'b1;
          min_we    = nb_is_min;
          max_we    = !nb_is_min;
          pos_next  = pos - 1'b1;
          state_next = (pos_next == '0) ? ST_RREQ : ST_LCMP;
        end else begin
          state_next = ST_RREQ;
        end
      end

      ST_RREQ: begin
        state_next = (NW'(pos) + 1'b1 >= n_slots) ? ST_FIN : ST_RCMP;
      end

      ST_RCMP: begin
        if (swap) begin
          ept_we     = 1'b1;
          min_we     = nb_is_min;
          max_we     = !nb_is_min;
          pos_next   = pos + 1'b1;
          state_next = (NW'(pos_next) + 1'b1 >= n_slots) ? ST_FIN : ST_RCMP;
        end else begin
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        ept_we    = 1'b1;
        ept_wdata = {mv_value, mv_is_min, key};
        if (mv_is_min) begin
          min_we     = 1'b1;
          min_waddr  = key;
          state_next = ST_MAXRD;
        end else begin
          max_we       = 1'b1;
          max_waddr    = key;
          max_pos_next = pos;
          state_next   = ST_RESRD;
        end
      end

      ST_MAXRD: begin
        pos_next       = max_rdata;
        mv_value_next  = hi;
        mv_is_min_next = 1'b0;
        state_next     = ST_LREQ;
      end

      ST_RESRD: begin
        done_next         = 1'b1;
        result_key_next   = rkey_wide[7:0];
        min_position_next = minp_wide[8:0];
        max_position_next = maxp_wide[8:0];
        status_next       = STATUS_OK;
        state_next        = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    key          <= key_next;
    hi           <= hi_next;
    mv_value     <= mv_value_next;
    mv_is_min    <= mv_is_min_next;
    pos          <= pos_next;
    max_pos      <= max_pos_next;
    result_key   <= result_key_next;
    min_position <= min_position_next;
    max_position <= max_position_next;
    status       <= status_next;
  end

endmodule

// ----- verif/sorted_endpoint_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_endpoint_table_core_tb
// Self-checking bench for one sweep-and-prune axis. A short directed list hits
// the value extremes, ties, inverted intervals, unknown keys and ignored key
// fields. Random traffic then fills the table to the full state and keeps
// moving objects, mostly by small steps, with ties and full-range jumps mixed
// in. A local copy of the sorted endpoint table predicts every result.
// ----------------------------------------------------------------------------
module sorted_endpoint_table_core_tb;
  import sept_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int OBJ_LIMIT   = 256;
  localparam int TARGET_OPS  = 1300;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 64;
  localparam int REPORT_CAP  = 50;
  localparam int UNIT        = 65536;

  typedef struct {
    logic               action;
    logic [7:0]         key;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 drain_first;
  } op_t;

  typedef struct {
    logic [7:0] key;
    logic [8:0] min_pos;
    logic [8:0] max_pos;
    logic [1:0] status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               action = ACT_INSERT;
  logic [7:0]         object_key = 8'd0;
  logic signed [31:0] min_value = 32'sd0;
  logic signed [31:0] max_value = 32'sd0;
  logic               busy;
  logic               done;
  logic [7:0]         result_key;
  logic [8:0]         min_position;
  logic [8:0]         max_position;
  logic [1:0]         status;

  sorted_endpoint_table_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .object_key   (object_key),
    .min_value    (min_value),
    .max_value    (max_value),
    .done         (done),
    .result_key   (result_key),
    .min_position (min_position),
    .max_position (max_position),
    .status       (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Endpoint table copy used for prediction
  // --------------------------------------------------------------------------
  logic signed [31:0] end_value [0:2*OBJ_LIMIT-1];
  logic               end_is_min [0:2*OBJ_LIMIT-1];
  logic [7:0]         end_owner [0:2*OBJ_LIMIT-1];
  logic [8:0]         min_slot [0:OBJ_LIMIT-1];
  logic [8:0]         max_slot [0:OBJ_LIMIT-1];
  int                 live_objects = 0;

  function automatic void repoint(int p);
    if (end_is_min[p]) min_slot[end_owner[p]] = 9'(p);
    else max_slot[end_owner[p]] = 9'(p);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] v;
    logic               m;
    logic [7:0]         o;
    v = end_value[a];
    m = end_is_min[a];
    o = end_owner[a];
    end_value[a]  = end_value[b];
    end_is_min[a] = end_is_min[b];
    end_owner[a]  = end_owner[b];
    end_value[b]  = v;
    end_is_min[b] = m;
    end_owner[b]  = o;
    repoint(a);
    repoint(b);
  endfunction

  // walk one endpoint left, then right, until it sits in order
  function automatic void settle_endpoint(int pos, int n);
    logic signed [31:0] v;
    logic               m;
    if (n < 2 || pos >= n) return;
    v = end_value[pos];
    m = end_is_min[pos];
    while (pos > 0 && (end_value[pos-1] > v ||
                       (end_value[pos-1] == v && m && !end_is_min[pos-1]))) begin
      swap_slots(pos, pos - 1);
      pos--;
    end
    while (pos + 1 < n && (end_value[pos+1] < v ||
                           (end_value[pos+1] == v && !m && end_is_min[pos+1]))) begin
      swap_slots(pos, pos + 1);
      pos++;
    end
  endfunction

  function automatic answer_t sweep_apply(op_t op);
    answer_t ans;
    int      k;
    int      n;
    ans.key     = op.key;
    ans.min_pos = 9'd0;
    ans.max_pos = 9'd0;
    ans.status  = STATUS_OK;
    k = op.key;
    if (op.action == ACT_INSERT) begin
      if (live_objects >= OBJ_LIMIT) begin
        ans.key    = 8'd0;
        ans.status = STATUS_FULL;
        return ans;
      end
      k = live_objects;
      n = 2 * k;
      end_value[n]    = op.lo;
      end_is_min[n]   = 1'b1;
      end_owner[n]    = 8'(k);
      end_value[n+1]  = op.hi;
      end_is_min[n+1] = 1'b0;
      end_owner[n+1]  = 8'(k);
      min_slot[k]     = 9'(n);
      max_slot[k]     = 9'(n + 1);
      live_objects++;
      settle_endpoint(min_slot[k], 2 * live_objects);
      settle_endpoint(max_slot[k], 2 * live_objects);
      ans.key = 8'(k);
    end else begin
      if (k >= live_objects) begin
        ans.status = STATUS_UNKNOWN;
        return ans;
      end
      n = 2 * live_objects;
      end_value[min_slot[k]] = op.lo;
      settle_endpoint(min_slot[k], n);
      end_value[max_slot[k]] = op.hi;
      settle_endpoint(max_slot[k], n);
    end
    ans.min_pos = min_slot[k];
    ans.max_pos = max_slot[k];
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation; tracks what the table will hold once items execute
  // --------------------------------------------------------------------------
  op_t                queued_ops[$];
  int                 total_ops = 0;
  int                 plan_count = 0;
  logic signed [31:0] plan_lo [0:OBJ_LIMIT-1];
  logic signed [31:0] plan_hi [0:OBJ_LIMIT-1];

  function automatic void queue_op(logic act, logic [7:0] key, logic signed [31:0] lo,
                                   logic signed [31:0] hi, bit drain);
    op_t op;
    op.action      = act;
    op.key         = key;
    op.lo          = lo;
    op.hi          = hi;
    op.drain_first = drain;
    queued_ops = {queued_ops, op};
    total_ops++;
    if (act == ACT_INSERT && plan_count < OBJ_LIMIT) begin
      plan_lo[plan_count] = lo;
      plan_hi[plan_count] = hi;
      plan_count++;
    end else if (act == ACT_MOVE && key < plan_count) begin
      plan_lo[key] = lo;
      plan_hi[key] = hi;
    end
  endfunction

  // mix of tie-prone grid values, a moderate band and the full range
  function automatic logic signed [31:0] draw_bound();
    int pick;
    int r;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      r = $urandom_range(0, 16);
      return (r - 8) * UNIT;
    end
    if (pick < 8) begin
      r = $urandom_range(0, 1 << 21);
      return r - (1 << 20);
    end
    return $urandom();
  endfunction

  function automatic logic signed [31:0] nudge(logic signed [31:0] v);
    int d;
    if ($urandom_range(0, 1) == 0) begin
      d = $urandom_range(0, 6);
      d = (d - 3) * UNIT;
    end else begin
      d = $urandom_range(0, 6 * UNIT);
      d = d - 3 * UNIT;
    end
    return v + d;
  endfunction

  function automatic void queue_fresh(logic act, logic [7:0] key, bit drain);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int                 w;
    lo = draw_bound();
    case ($urandom_range(0, 3))
      0: hi = draw_bound();
      1: hi = lo;
      default: begin
        w  = $urandom_range(0, 4 * UNIT);
        hi = lo + w;
      end
    endcase
    queue_op(act, key, lo, hi, drain);
  endfunction

  // small step of a live object, sometimes flipped into an inverted interval
  function automatic void queue_drift(bit drain);
    int                 k;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    k  = $urandom_range(0, plan_count - 1);
    lo = nudge(plan_lo[k]);
    hi = nudge(plan_hi[k]);
    if ($urandom_range(0, 9) == 0) queue_op(ACT_MOVE, 8'(k), hi, lo, drain);
    else queue_op(ACT_MOVE, 8'(k), lo, hi, drain);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of items with random idle gaps
  // --------------------------------------------------------------------------
  answer_t pending_answers[$];
  op_t     cur_op;
  int      in_flight = 0;
  int      accepted_ops = 0;
  int      burst_left = 8;
  int      idle_left = 0;

  always @(posedge clk) begin
    bit took;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        pending_answers = {pending_answers, sweep_apply(cur_op)};
        accepted_ops++;
        in_flight++;
      end
      if (done) in_flight--;
      if (took || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (queued_ops.size() == 0) begin
          start <= 1'b0;
        end else if (queued_ops[0].drain_first && in_flight != 0) begin
          start <= 1'b0;
        end else begin
          cur_op = queued_ops.pop_front();
          start      <= 1'b1;
          action     <= cur_op.action;
          object_key <= cur_op.key;
          min_value  <= cur_op.lo;
          max_value  <= cur_op.hi;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1, 2: idle_left = 0;
              7:       idle_left = $urandom_range(20, 40);
              default: idle_left = $urandom_range(1, 12);
            endcase
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare every result with the oldest prediction
  // --------------------------------------------------------------------------
  int error_count = 0;
  int checked = 0;
  int seen_ok = 0;
  int seen_full = 0;
  int seen_unknown = 0;

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      error_count++;
      if (error_count <= REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t ns: result with nothing expected, expected none, actual key %0d",
                   $time, result_key);
      end else begin
        want = pending_answers.pop_front();
        check_field("result_key", want.key, result_key);
        check_field("min_position", want.min_pos, min_position);
        check_field("max_position", want.max_pos, max_position);
        check_field("status", want.status, status);
        checked++;
        case (want.status)
          STATUS_FULL:    seen_full++;
          STATUS_UNKNOWN: seen_unknown++;
          default:        seen_ok++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no item taken and no result for too long
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // directed: empty table, extremes, ties, inverted intervals, unknown keys
    queue_op(ACT_MOVE,   8'd0,   32'sd0, 32'sd0, 1'b0);
    queue_op(ACT_INSERT, 8'hA5,  -UNIT, UNIT, 1'b0);
    queue_op(ACT_INSERT, 8'hFF,  32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    queue_op(ACT_INSERT, 8'h00,  32'h80000000, 32'h80000000, 1'b0);
    queue_op(ACT_INSERT, 8'h5A,  UNIT, UNIT, 1'b0);
    queue_op(ACT_INSERT, 8'h01,  -UNIT, -UNIT, 1'b0);
    queue_op(ACT_INSERT, 8'h80,  3 * UNIT, -3 * UNIT, 1'b0);
    queue_op(ACT_MOVE,   8'd6,   32'sd0, 32'sd0, 1'b0);
    queue_op(ACT_MOVE,   8'hFF,  32'sd0, 32'sd0, 1'b0);
    queue_op(ACT_MOVE,   8'h80,  UNIT, UNIT, 1'b0);
    queue_op(ACT_MOVE,   8'd0,   32'h80000000, 32'h7FFFFFFF, 1'b0);
    queue_op(ACT_MOVE,   8'd0,   32'h7FFFFFFF, 32'h80000000, 1'b0);
    queue_op(ACT_MOVE,   8'd1,   32'h80000000, 32'h80000000, 1'b0);
    queue_op(ACT_MOVE,   8'd2,   32'h80000000, 32'h80000000, 1'b0);
    queue_op(ACT_MOVE,   8'd3,   UNIT, UNIT, 1'b0);
    queue_op(ACT_MOVE,   8'd5,   32'sd0, 32'sd0, 1'b0);
    queue_op(ACT_INSERT, 8'h3C,  32'sd0, 32'sd0, 1'b0);
    queue_op(ACT_MOVE,   8'd6,   32'hFFFFFFFF, 32'sd1, 1'b0);
    queue_op(ACT_MOVE,   8'd4,   UNIT, -UNIT, 1'b0);

    // growth: mostly inserts until the table is full, with moves mixed in
    queue_drift(1'b1);
    while (plan_count < OBJ_LIMIT) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: queue_drift($urandom_range(0, 149) == 0);
        4:          queue_fresh(ACT_MOVE, 8'($urandom_range(0, plan_count - 1)), 1'b0);
        5: begin
          if (plan_count < OBJ_LIMIT - 1)
            queue_fresh(ACT_MOVE, 8'($urandom_range(plan_count, OBJ_LIMIT - 1)), 1'b0);
          else
            queue_fresh(ACT_MOVE, 8'hFF, 1'b0);
        end
        default:    queue_fresh(ACT_INSERT, 8'($urandom()), 1'b0);
      endcase
    end

    // full table: inserts are refused
    queue_fresh(ACT_INSERT, 8'($urandom()), 1'b1);
    repeat (5) queue_fresh(ACT_INSERT, 8'($urandom()), 1'b0);

    // steady state: coherent motion, some jumps, refused inserts
    while (total_ops < TARGET_OPS) begin
      case ($urandom_range(0, 19))
        0, 1:    queue_fresh(ACT_MOVE, 8'($urandom_range(0, OBJ_LIMIT - 1)),
                             $urandom_range(0, 149) == 0);
        2:       queue_fresh(ACT_INSERT, 8'($urandom()), 1'b0);
        default: queue_drift($urandom_range(0, 149) == 0);
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_ops < total_ops) @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d results checked): %0d ok, %0d refused on full table,",
             accepted_ops, checked, seen_ok, seen_full);
    $display("%0d unknown keys, final object count %0d, %0d mismatches",
             seen_unknown, live_objects, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
